FILE: design/grmm_pkg.sv
package grmm_pkg;

   // Ring geometry: element degree and coefficient width.
   localparam int DEGREE     = 4;
   localparam int COEFF_BITS = 16;
   localparam int ROW_BITS   = $clog2(DEGREE);
   localparam int RING_BITS_W = 5;
   localparam int CSR_INDEX_BITS = $clog2(DEGREE + 1);

   typedef logic [COEFF_BITS-1:0]  coef_type;
   typedef coef_type [DEGREE-1:0]  col_type;   // one column, element j is coefficient j
   typedef col_type  [DEGREE-1:0]  mat_type;   // columns, element n is column n
   typedef logic [ROW_BITS-1:0]    row_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [RING_BITS_W-1:0] ring_bits_type;

   // Register indexes of the configuration port.
   localparam csr_index_type CSR_MODULUS_0 = csr_index_type'(0);
   localparam csr_index_type CSR_RING_BITS = csr_index_type'(DEGREE);

   // Reset values of the configuration registers.
   localparam coef_type      MODULUS_0_RESET = coef_type'(1);
   localparam coef_type      MODULUS_1_RESET = coef_type'(1);
   localparam ring_bits_type RING_BITS_RESET = ring_bits_type'(16);

   typedef struct packed {
      logic [15:0] coeff_0;
      logic [15:0] coeff_1;
      logic [15:0] coeff_2;
      logic [15:0] coeff_3;
   } req_data_type;

   typedef struct packed {
      logic [1:0]  row_index;
      logic [15:0] entry_0;
      logic [15:0] entry_1;
      logic [15:0] entry_2;
      logic [15:0] entry_3;
      logic        last_row;
   } rsp_data_type;

   // Settings shared by all column stages.
   typedef struct packed {
      col_type  modulus;
      coef_type mask;
   } grmm_cfg_type;

   // Mask of the low k bits; k above the coefficient width keeps every bit.
   function automatic coef_type ring_mask(input ring_bits_type bits);
      coef_type result;
      if (int'(bits) >= COEFF_BITS) begin
         result = '1;
      end else begin
         result = (coef_type'(1) << bits) - coef_type'(1);
      end
      return result;
   endfunction

endpackage

FILE: design/grmm_col_stage.sv
module grmm_col_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  grmm_pkg::mat_type     in_hist,
   input  grmm_pkg::grmm_cfg_type cfg,
   output logic                  out_valid,
   output grmm_pkg::mat_type     out_hist
);
   import grmm_pkg::*;

   logic     valid_ff;
   mat_type  hist_ff;
   mat_type  hist_in;
   col_type  cur_col;
   col_type  next_col;
   coef_type top;
   logic [2*COEFF_BITS-1:0] prod [DEGREE];

   // Multiply the newest column by x and reduce modulo the monic f.
   always_comb begin
      cur_col = in_hist[DEGREE-1];
      top     = cur_col[DEGREE-1];
      for (int j = 0; j < DEGREE; j++) begin
         prod[j] = cfg.modulus[j] * top;
      end
      next_col[0] = (coef_type'(0) - prod[0][COEFF_BITS-1:0]) & cfg.mask;
      for (int j = 1; j < DEGREE; j++) begin
         next_col[j] = (cur_col[j-1] - prod[j][COEFF_BITS-1:0]) & cfg.mask;
      end
   end

   // The column history shifts down by one and the new column enters at the top.
   always_comb begin
      for (int n = 0; n < DEGREE - 1; n++) begin
         hist_in[n] = in_hist[n+1];
      end
      hist_in[DEGREE-1] = next_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hist_ff <= hist_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_hist  = hist_ff;

endmodule

FILE: design/galois_ring_mult_matrix_top.sv
// Path: an accepted element passes the input stage, the column stages and the output
// holding register before its first row shows. Throughput: one row per cycle while
// rsp_stall is low, DEGREE rows per element; the column pipeline takes an element
// every cycle unless stalled. Reset is synchronous, active high; it clears all valid
// bits and the row counter and returns the modulus to 1,1,0,0 and ring_bits to 16.
module galois_ring_mult_matrix_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  grmm_pkg::req_data_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output grmm_pkg::rsp_data_type        rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  grmm_pkg::csr_index_type       csr_index,
   input  logic [15:0]                   csr_data
);
   import grmm_pkg::*;

   col_type       modulus_ff;
   ring_bits_type ring_bits_ff;
   grmm_cfg_type  cfg;

   logic    pipe_valid [DEGREE];
   mat_type pipe_hist  [DEGREE];
   logic    pipe_adv   [DEGREE];
   logic    s0_valid_ff;
   mat_type s0_hist_ff;
   mat_type s0_hist_in;

   mat_type mat_ff;
   row_type row_ff;
   logic    out_valid_ff;
   logic    rsp_xfer;
   logic    last_xfer;
   logic    ser_ready;
   logic    ser_load;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         // Coefficients above the first two reset to zero.
         modulus_ff    <= col_type'({MODULUS_1_RESET, MODULUS_0_RESET});
         ring_bits_ff  <= RING_BITS_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index < CSR_RING_BITS) begin
            modulus_ff[csr_index[ROW_BITS-1:0] - row_type'(CSR_MODULUS_0)] <= csr_data;
         end else if (csr_index == CSR_RING_BITS) begin
            ring_bits_ff <= csr_data[RING_BITS_W-1:0];
         end
      end
   end

   assign cfg.modulus = modulus_ff;
   assign cfg.mask    = ring_mask(ring_bits_ff);

   // Row serializer control: a new matrix loads when the holding register is
   // empty or its last row is being transferred.
   assign rsp_xfer  = out_valid_ff && !rsp_stall;
   assign last_xfer = rsp_xfer && (row_ff == row_type'(DEGREE - 1));
   assign ser_ready = !out_valid_ff || last_xfer;
   assign ser_load  = pipe_valid[DEGREE-1] && ser_ready;

   // Pipeline advance: a stage moves when it is empty or the next one moves.
   always_comb begin
      pipe_adv[DEGREE-1] = !pipe_valid[DEGREE-1] || ser_ready;
      for (int s = DEGREE - 2; s >= 0; s--) begin
         pipe_adv[s] = !pipe_valid[s] || pipe_adv[s+1];
      end
   end

   assign req_stall = !pipe_adv[0];

   // Input stage: the masked element becomes column 0 at the top of the history.
   always_comb begin
      s0_hist_in = '0;
      s0_hist_in[DEGREE-1] = {req_data.coeff_3, req_data.coeff_2,
                              req_data.coeff_1, req_data.coeff_0} & {DEGREE{cfg.mask}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (pipe_adv[0]) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv[0]) begin
         s0_hist_ff <= s0_hist_in;
      end
   end

   assign pipe_valid[0] = s0_valid_ff;
   assign pipe_hist[0]  = s0_hist_ff;

   // One stage per further column.
   for (genvar s = 1; s < DEGREE; s++) begin : g_stage
      grmm_col_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (pipe_adv[s]),
         .in_valid  (pipe_valid[s-1]),
         .in_hist   (pipe_hist[s-1]),
         .cfg       (cfg),
         .out_valid (pipe_valid[s]),
         .out_hist  (pipe_hist[s])
      );
   end

   // Output holding register and row counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         row_ff       <= '0;
      end else if (ser_load) begin
         out_valid_ff <= 1'b1;
         row_ff       <= '0;
      end else if (last_xfer) begin
         out_valid_ff <= 1'b0;
         row_ff       <= '0;
      end else if (rsp_xfer) begin
         row_ff <= row_ff + row_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         mat_ff <= pipe_hist[DEGREE-1];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_data.row_index = row_ff;
   assign rsp_data.entry_0   = mat_ff[0][row_ff];
   assign rsp_data.entry_1   = mat_ff[1][row_ff];
   assign rsp_data.entry_2   = mat_ff[2][row_ff];
   assign rsp_data.entry_3   = mat_ff[3][row_ff];
   assign rsp_data.last_row  = (row_ff == row_type'(DEGREE - 1));

`ifndef SYNTHESIS
   a_row_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !last_xfer) |=> (rsp_valid && row_ff == $past(row_ff) + row_type'(1)))
      else $error("row counter did not advance after a non-final row transfer");

   a_matrix_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !last_xfer) |=> $stable(mat_ff))
      else $error("matrix changed before its last row was transferred");

   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> pipe_valid[0])
      else $error("transferred element did not enter the input stage");

   a_new_matrix_row0: assert property (@(posedge clock) disable iff (reset)
      ser_load |=> (rsp_valid && row_ff == '0))
      else $error("new matrix did not start at row zero");
`endif

endmodule
